### design/time_of_day_palette_tint_macros.svh
// Assertion macros for the time-of-day palette tint block
`ifndef TIME_OF_DAY_PALETTE_TINT_MACROS_SVH
`define TIME_OF_DAY_PALETTE_TINT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TDPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/tdpt_pkg.sv
// Types and constants shared by the palette tint pipeline
`timescale 1ns / 1ps
package tdpt_pkg;

    localparam int COLOR_W = 16;
    localparam int INDEX_W = 9;
    localparam int CHAN_W = 5;
    localparam int HOUR_W = 5;
    localparam int MINUTE_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam int GAIN_W = 9;
    localparam int ABS_W = 8;
    localparam int MAG_W = ABS_W + MINUTE_W;
    localparam int RECIP_W = 15;
    localparam int PROD_W = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT = 20;
    localparam int SCALE_W = CHAN_W + GAIN_W;
    localparam int GAIN_FRAC = 8;

    // ceil(2^20 / 60): exact floor division for magnitudes below 23831
    localparam logic [RECIP_W-1:0] RECIP_60 = 15'd17477;
    localparam logic [SCALE_W:0] ROUND_HALF = 15'd128;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 5'd31;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUTE = 2'd2;

    localparam logic [HOUR_W-1:0] HOUR_RESET = 5'd12;
    localparam logic [HOUR_W-1:0] HOUR_DAWN_IN = 5'd5;
    localparam logic [HOUR_W-1:0] HOUR_DAWN_OUT = 5'd6;
    localparam logic [HOUR_W-1:0] HOUR_DAY_FIRST = 5'd7;
    localparam logic [HOUR_W-1:0] HOUR_DAY_LAST = 5'd17;
    localparam logic [HOUR_W-1:0] HOUR_DUSK_IN = 5'd18;
    localparam logic [HOUR_W-1:0] HOUR_DUSK_OUT = 5'd19;

    typedef logic [GAIN_W-1:0] t_gain;
    typedef t_gain [2:0] t_gain_rgb;
    typedef logic [MAG_W-1:0] t_mag;

    // channel order: [0] red, [1] green, [2] blue
    localparam t_gain_rgb GAINS_DAY = {9'd256, 9'd256, 9'd256};
    localparam t_gain_rgb GAINS_DAWN = {9'd208, 9'd256, 9'd288};
    localparam t_gain_rgb GAINS_DUSK = {9'd144, 9'd208, 9'd288};
    localparam t_gain_rgb GAINS_NIGHT = {9'd176, 9'd144, 9'd128};

    typedef struct packed {
        logic en;
        logic [HOUR_W-1:0] hour;
        logic [MINUTE_W-1:0] minute;
    } t_cfg;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [INDEX_W-1:0] index;
        logic last;
    } t_item;

    typedef struct packed {
        t_item item;
        logic en;
        t_gain_rgb start;
        logic [2:0] neg;
        t_mag [2:0] mag;
    } t_s1;

    typedef struct packed {
        t_item item;
        logic en;
        t_gain_rgb gain;
    } t_s2;

endpackage

### design/tdpt_intf.sv
// Valid/ready word channels for palette colors in and tinted colors out
`timescale 1ns / 1ps
interface tdpt_in_if import tdpt_pkg::*; ();
    logic valid;
    logic ready;
    logic [COLOR_W-1:0] color_in;
    logic [INDEX_W-1:0] entry_index;
    logic last_entry;

    modport source (output valid, color_in, entry_index, last_entry, input ready);
    modport sink (input valid, color_in, entry_index, last_entry, output ready);
endinterface

interface tdpt_out_if import tdpt_pkg::*; ();
    logic valid;
    logic ready;
    logic [COLOR_W-1:0] color_out;
    logic [INDEX_W-1:0] entry_index_out;
    logic last_out;

    modport source (output valid, color_out, entry_index_out, last_out, input ready);
    modport sink (input valid, color_out, entry_index_out, last_out, output ready);
endinterface

### design/tdpt_gain_sel.sv
// Stage 1: pick the gain profiles for the hour and form the blend magnitudes
`timescale 1ns / 1ps
module tdpt_gain_sel import tdpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_s1   o_s1
);

    t_gain_rgb from_g;
    t_gain_rgb to_g;
    logic signed [GAIN_W:0] diff [3];
    logic [GAIN_W:0] absd [3];
    t_s1 n_s1;
    logic r_valid;
    t_s1 r_s1;

    always_comb begin
        case (i_cfg.hour)
            HOUR_DAWN_IN: begin
                from_g = GAINS_NIGHT;
                to_g = GAINS_DAWN;
            end
            HOUR_DAWN_OUT: begin
                from_g = GAINS_DAWN;
                to_g = GAINS_DAY;
            end
            HOUR_DUSK_IN: begin
                from_g = GAINS_DAY;
                to_g = GAINS_DUSK;
            end
            HOUR_DUSK_OUT: begin
                from_g = GAINS_DUSK;
                to_g = GAINS_NIGHT;
            end
            default: begin
                if (i_cfg.hour inside {[HOUR_DAY_FIRST:HOUR_DAY_LAST]}) begin
                    from_g = GAINS_DAY;
                    to_g = GAINS_DAY;
                end else begin
                    from_g = GAINS_NIGHT;
                    to_g = GAINS_NIGHT;
                end
            end
        endcase
    end

    always_comb begin
        n_s1.item = i_item;
        n_s1.en = i_cfg.en;
        n_s1.start = from_g;
        for (int ch = 0; ch < 3; ch++) begin
            diff[ch] = $signed({1'b0, to_g[ch]}) - $signed({1'b0, from_g[ch]});
            absd[ch] = diff[ch][GAIN_W] ? $unsigned(-diff[ch]) : $unsigned(diff[ch]);
            n_s1.neg[ch] = diff[ch][GAIN_W];
            n_s1.mag[ch] = MAG_W'(absd[ch][ABS_W-1:0] * i_cfg.minute);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1 = r_s1;

endmodule

### design/tdpt_gain_div.sv
// Stage 2: divide the blend magnitudes by 60 and form the channel gains
`timescale 1ns / 1ps
module tdpt_gain_div import tdpt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_valid,
    input  t_s1  i_s1,
    output logic o_valid,
    output t_s2  o_s2
);

    logic [PROD_W-1:0] prod [3];
    t_gain quo [3];
    t_s2 n_s2;
    logic r_valid;
    t_s2 r_s2;

    always_comb begin
        n_s2.item = i_s1.item;
        n_s2.en = i_s1.en;
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = PROD_W'(i_s1.mag[ch] * RECIP_60);
            quo[ch] = GAIN_W'(prod[ch] >> RECIP_SHIFT);
            if (i_s1.neg[ch]) begin
                n_s2.gain[ch] = (quo[ch] > i_s1.start[ch]) ? '0 : i_s1.start[ch] - quo[ch];
            end else begin
                n_s2.gain[ch] = GAIN_W'(i_s1.start[ch] + quo[ch]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2 = r_s2;

endmodule

### design/tdpt_scale.sv
// Stage 3: when tint is on, scale each channel by its gain, round and saturate; hold the output word
`timescale 1ns / 1ps
module tdpt_scale import tdpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_valid,
    input  t_s2   i_s2,
    output logic  o_valid,
    output t_item o_item
);

    logic [SCALE_W-1:0] prod [3];
    logic [SCALE_W:0] rnd [3];
    logic [SCALE_W-GAIN_FRAC:0] whole [3];
    logic [CHAN_W-1:0] chan [3];
    t_item n_item;
    logic r_valid;
    t_item r_item;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = SCALE_W'(i_s2.item.color[ch*CHAN_W +: CHAN_W] * i_s2.gain[ch]);
            rnd[ch] = (SCALE_W + 1)'({1'b0, prod[ch]} + ROUND_HALF);
            whole[ch] = rnd[ch][SCALE_W:GAIN_FRAC];
            chan[ch] = (whole[ch] > (SCALE_W - GAIN_FRAC + 1)'(CHAN_MAX))
                ? CHAN_MAX : whole[ch][CHAN_W-1:0];
        end
        n_item = i_s2.item;
        if (i_s2.en) begin
            n_item.color = {i_s2.item.color[COLOR_W-1], chan[2], chan[1], chan[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

endmodule

### design/time_of_day_palette_tint.sv
// An accepted input word passes the gain select, divide by 60 and scale registers in turn.
// Throughput: one word per cycle unless the output stalls; three register stages in all.
// Each stage loads when it is empty or the stage after it moves, so bubbles collapse.
// Synchronous active-low reset clears the stage valid bits and sets enable 0,
// hour 12, minute 0.
`timescale 1ns / 1ps
`include "time_of_day_palette_tint_macros.svh"
module time_of_day_palette_tint import tdpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tdpt_in_if.sink               i_pix,
    tdpt_out_if.source            o_pix
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic adv1;
    logic adv2;
    logic adv3;
    logic v1;
    logic v2;
    logic v3;
    t_item in_item;
    t_s1 s1;
    t_s2 s2;
    t_item out_item;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: n_cfg.en = i_cfg_data[0];
                CFG_HOUR:   n_cfg.hour = i_cfg_data[HOUR_W-1:0];
                CFG_MINUTE: n_cfg.minute = i_cfg_data[MINUTE_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{en: 1'b0, hour: HOUR_RESET, minute: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign adv3 = !v3 || o_pix.ready;
    assign adv2 = !v2 || adv3;
    assign adv1 = !v1 || adv2;
    assign i_pix.ready = adv1;

    assign in_item = '{color: i_pix.color_in, index: i_pix.entry_index,
                       last: i_pix.last_entry};

    tdpt_gain_sel u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv1),
        .i_valid (i_pix.valid),
        .i_item  (in_item),
        .i_cfg   (r_cfg),
        .o_valid (v1),
        .o_s1    (s1)
    );

    tdpt_gain_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv2),
        .i_valid (v1),
        .i_s1    (s1),
        .o_valid (v2),
        .o_s2    (s2)
    );

    tdpt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv3),
        .i_valid (v2),
        .i_s2    (s2),
        .o_valid (v3),
        .o_item  (out_item)
    );

    assign o_pix.valid = v3;
    assign o_pix.color_out = out_item.color;
    assign o_pix.entry_index_out = out_item.index;
    assign o_pix.last_out = out_item.last;

    `TDPT_ASSERT_NEXT(a_s2_hold, i_clk, i_rst_n, v2 && v3 && !o_pix.ready, v2 && $stable(s2), "stage 2 word lost under stall")
    `TDPT_ASSERT_NOW(a_gain_range, i_clk, i_rst_n, v2, s2.gain[0] >= 9'd120 && s2.gain[0] <= 9'd296 && s2.gain[1] >= 9'd120 && s2.gain[1] <= 9'd296 && s2.gain[2] >= 9'd120 && s2.gain[2] <= 9'd296, "blended gain out of range")
    `TDPT_ASSERT_NEXT(a_bypass, i_clk, i_rst_n, v2 && !s2.en && adv3, o_pix.color_out == $past(s2.item.color), "disabled word altered")

endmodule

### tb/tint_scoreboard.sv
// Watches both word channels and the register port, predicts each tinted color and checks it
`timescale 1ns / 1ps
module tint_scoreboard import tdpt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tdpt_in_if                    i_pix,
    tdpt_out_if                   i_res,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int BLEND_SPAN = 60;
    localparam int GAIN_UNITY = 256;
    localparam int CHAN_TOP = 31;

    typedef struct packed {
        logic signed [15:0] r;
        logic signed [15:0] g;
        logic signed [15:0] b;
    } t_rgb_gain;

    localparam t_rgb_gain DAY_GAIN   = {16'sd256, 16'sd256, 16'sd256};
    localparam t_rgb_gain DAWN_GAIN  = {16'sd288, 16'sd256, 16'sd208};
    localparam t_rgb_gain DUSK_GAIN  = {16'sd288, 16'sd208, 16'sd144};
    localparam t_rgb_gain NIGHT_GAIN = {16'sd128, 16'sd144, 16'sd176};

    logic               tint_on;
    logic [HOUR_W-1:0]   tint_hour;
    logic [MINUTE_W-1:0] tint_minute;
    t_item              tinted_due[$];

    function automatic int blend_one(int from_g, int to_g, int m);
        return from_g + ((to_g - from_g) * m) / BLEND_SPAN;
    endfunction

    function automatic t_rgb_gain blend_gain(t_rgb_gain from_g, t_rgb_gain to_g, int m);
        t_rgb_gain mixed;
        mixed.r = 16'(blend_one(int'(from_g.r), int'(to_g.r), m));
        mixed.g = 16'(blend_one(int'(from_g.g), int'(to_g.g), m));
        mixed.b = 16'(blend_one(int'(from_g.b), int'(to_g.b), m));
        return mixed;
    endfunction

    function automatic t_rgb_gain gain_for_time(logic [HOUR_W-1:0] hr, logic [MINUTE_W-1:0] mn);
        int m;
        m = int'(mn);
        case (hr)
            HOUR_DAWN_IN:  return blend_gain(NIGHT_GAIN, DAWN_GAIN, m);
            HOUR_DAWN_OUT: return blend_gain(DAWN_GAIN, DAY_GAIN, m);
            HOUR_DUSK_IN:  return blend_gain(DAY_GAIN, DUSK_GAIN, m);
            HOUR_DUSK_OUT: return blend_gain(DUSK_GAIN, NIGHT_GAIN, m);
            default: begin
                if (hr >= HOUR_DAY_FIRST && hr <= HOUR_DAY_LAST)
                    return DAY_GAIN;
                return NIGHT_GAIN;
            end
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] scale_channel(logic [CHAN_W-1:0] c, int g);
        int v;
        v = (int'(c) * (g < 0 ? 0 : g) + GAIN_UNITY / 2) / GAIN_UNITY;
        return (v > CHAN_TOP) ? CHAN_W'(CHAN_TOP) : CHAN_W'(v);
    endfunction

    function automatic logic [COLOR_W-1:0] tinted_color(logic [COLOR_W-1:0] c);
        t_rgb_gain gn;
        if (!tint_on)
            return c;
        gn = gain_for_time(tint_hour, tint_minute);
        return {c[15],
                scale_channel(c[14:10], int'(gn.b)),
                scale_channel(c[9:5], int'(gn.g)),
                scale_channel(c[4:0], int'(gn.r))};
    endfunction

    always @(posedge i_clk) begin
        t_item want;
        t_item got;
        if (!i_rst_n) begin
            tint_on = 1'b0;
            tint_hour = HOUR_RESET;
            tint_minute = '0;
            tinted_due.delete();
            o_fail_count = 0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                want.color = tinted_color(i_pix.color_in);
                want.index = i_pix.entry_index;
                want.last = i_pix.last_entry;
                tinted_due.push_back(want);
            end
            if (i_res.valid && i_res.ready) begin
                got.color = i_res.color_out;
                got.index = i_res.entry_index_out;
                got.last = i_res.last_out;
                if (tinted_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected word color %h index %0d last %b",
                             $time, got.color, got.index, got.last);
                end else begin
                    want = tinted_due.pop_front();
                    if (got.color !== want.color || got.index !== want.index
                            || got.last !== want.last) begin
                        o_fail_count++;
                        $display("%0t: expected color %h index %0d last %b, got color %h index %0d last %b",
                                 $time, want.color, want.index, want.last,
                                 got.color, got.index, got.last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE: tint_on = i_cfg_data[0];
                    CFG_HOUR:   tint_hour = i_cfg_data[HOUR_W-1:0];
                    CFG_MINUTE: tint_minute = i_cfg_data[MINUTE_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = tinted_due.size();
    end

endmodule

### tb/testbench.sv
// Drives palette color words and register settings into the tint block and reports the verdict
`timescale 1ns / 1ps
module testbench;
    import tdpt_pkg::*;

    localparam int PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 200;
    localparam int WORDS_PER_PHASE = 49;
    localparam int RANDOM_PHASES = 27;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [7:0][COLOR_W-1:0] EDGE_COLORS = {
        16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000,
        16'h001F, 16'h03E0, 16'hFC00, 16'h0421
    };
    localparam logic [3:0][HOUR_W-1:0] TRANSITION_HOURS = {
        HOUR_DAWN_IN, HOUR_DAWN_OUT, HOUR_DUSK_IN, HOUR_DUSK_OUT
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    tx_steady;
    bit                    rx_steady;
    bit                    rx_hold_req;

    tdpt_in_if  pix_in();
    tdpt_out_if pix_out();

    time_of_day_palette_tint u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    tint_scoreboard u_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_in),
        .i_res        (pix_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [COLOR_W-1:0] color, input logic [INDEX_W-1:0] index,
                             input logic last);
        int gap;
        gap = pick_gap(tx_steady);
        repeat (gap) begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.color_in <= color;
        pix_in.entry_index <= index;
        pix_in.last_entry <= last;
        do @(posedge clk); while (!pix_in.ready);
        @(negedge clk);
    endtask

    task automatic drain_phase();
        pix_in.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic choose_setting(input int p, output logic en, output logic [HOUR_W-1:0] hr,
                                  output logic [MINUTE_W-1:0] mn);
        en = 1'b1;
        case (p)
            0:  begin hr = 5'd5;  mn = 6'd0;  end
            1:  begin hr = 5'd5;  mn = 6'd59; end
            2:  begin hr = 5'd5;  mn = 6'd63; end
            3:  begin hr = 5'd6;  mn = 6'd30; end
            4:  begin hr = 5'd6;  mn = 6'd63; end
            5:  begin hr = 5'd18; mn = 6'd1;  end
            6:  begin hr = 5'd18; mn = 6'd59; end
            7:  begin hr = 5'd19; mn = 6'd45; end
            8:  begin hr = 5'd19; mn = 6'd63; end
            9:  begin hr = 5'd7;  mn = 6'd0;  end
            10: begin hr = 5'd17; mn = 6'd59; end
            11: begin hr = 5'd4;  mn = 6'd59; end
            12: begin hr = 5'd20; mn = 6'd0;  end
            13: begin hr = 5'd0;  mn = 6'd0;  end
            14: begin hr = 5'd23; mn = 6'd59; end
            15: begin hr = 5'd24; mn = 6'd10; end
            16: begin en = 1'b0; hr = 5'd19; mn = 6'd30; end
            17: begin hr = 5'd31; mn = 6'd63; end
            default: begin
                en = ($urandom_range(0, 5) != 0);
                if ($urandom_range(0, 1) == 1)
                    hr = TRANSITION_HOURS[2'($urandom_range(0, 3))];
                else
                    hr = HOUR_W'($urandom_range(0, 31));
                mn = MINUTE_W'($urandom_range(0, 63));
            end
        endcase
    endtask

    // receiving side: random stalls, steady stretches, and a long hold on request
    initial begin : drain_side
        int stall_left;
        int open_left;
        pix_out.ready = 1'b0;
        stall_left = 0;
        open_left = 0;
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                pix_out.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_out.ready <= 1'b1;
                if (open_left > 0) begin
                    open_left--;
                end else begin
                    open_left = $urandom_range(0, 24);
                    stall_left = pick_gap(rx_steady);
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        logic                en;
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mn;
        logic [INDEX_W-1:0]  next_index;
        int                  run_left;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ENABLE;
        cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.color_in = '0;
        pix_in.entry_index = '0;
        pix_in.last_entry = 1'b0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        rx_hold_req = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // edge colors under reset values, then tint on at noon, then an hour past 23
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                write_reg(CFG_ENABLE, 6'd1);
                cfg_we <= 1'b0;
            end else if (ph == 2) begin
                write_reg(CFG_HOUR, 6'd31);
                write_reg(CFG_MINUTE, 6'd63);
                write_reg(CFG_SPARE, 6'h2A);
                cfg_we <= 1'b0;
            end
            for (int i = 0; i < 8; i++) begin
                send_word(EDGE_COLORS[i],
                          (i == 0) ? 9'd0 : (i == 1) ? 9'd511 : INDEX_W'($urandom_range(0, 511)),
                          i == 7);
            end
            drain_phase();
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            choose_setting(p, en, hr, mn);
            write_reg(CFG_ENABLE, {(CFG_DATA_W - 1)'($urandom_range(0, 31)), en});
            write_reg(CFG_HOUR, {(CFG_DATA_W - HOUR_W)'($urandom_range(0, 1)), hr});
            write_reg(CFG_MINUTE, mn);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;
            tx_steady = (p % 5 == 0) || (p % 5 == 2) || (p == 3) || (p == 19);
            rx_steady = (p % 5 == 0);
            if (p == 3 || p == 19)
                rx_hold_req = 1'b1;
            run_left = 0;
            next_index = '0;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(1, 40);
                    next_index = INDEX_W'($urandom_range(0, 511));
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_word(COLOR_W'($urandom), INDEX_W'($urandom), 1'($urandom));
                end else begin
                    send_word(COLOR_W'($urandom), next_index,
                              run_left == 1 || n == WORDS_PER_PHASE - 1);
                    next_index++;
                    run_left--;
                end
            end
            drain_phase();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
